// ===== sv/kalt_pkg.sv =====
// Shared types and constants for the keyed access list table.
`timescale 1ns / 1ps
package kalt_pkg;

  localparam int KEY_W = 256;
  localparam int PERM_W = 8;
  localparam int TIME_W = 32;
  localparam int LEN_W = 6;
  localparam int CMD_W = 3;
  localparam logic [TIME_W-1:0] TIME_MAX = 32'hFFFF_FFFF;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPLY  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TOUCH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] REG_ROLE_MASK  = 2'd0;
  localparam logic [1:0] REG_GUEST_ROLE = 2'd1;
  localparam logic [1:0] REG_ADMIN_ROLE = 2'd2;

  // One table entry as it travels along the chain.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PERM_W-1:0] perm;
    logic [TIME_W-1:0] atime;
  } entry_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic             shift;   // cells at or above the target take the next entry
    logic             rotate;  // every cell takes the next entry; last takes slot 0
    logic             write;   // write entry at the target cell
    logic             touch;   // write activity only at the target cell
  } cell_ctl_t;

  // Byte-wise match mask for the first len bytes.
  function automatic logic [KEY_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    for (int b = 0; b < KEY_W / 8; b++) begin
      m[b*8 +: 8] = (b < int'(len)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== sv/kalt_cell.sv =====
// One storage cell of the entry chain.
`timescale 1ns / 1ps
module kalt_cell
  import kalt_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              here,       // this cell is the write target
  input  logic              above,      // this cell sits at or above the target
  input  entry_t            wr_entry,
  input  logic [TIME_W-1:0] wr_time,
  input  entry_t            from_next,  // neighbor entry for shifting
  output entry_t            held
);

  entry_t ent;

  always_ff @(posedge clk) begin
    if (ctl.write && here) begin
      ent <= wr_entry;
    end else if (ctl.touch && here) begin
      ent.atime <= wr_time;
    end else if (ctl.rotate || (ctl.shift && above)) begin
      ent <= from_next;
    end
  end

  assign held = ent;

endmodule

// ===== sv/keyed_access_list_table.sv =====
// Top level: command sequencer over a rotating chain of entry cells.
//
// channel   | direction | handshake       | payload
// ----------+-----------+-----------------+------------------------------
// s_axis    | in        | tvalid/tready   | command, key, length, perm, time
// m_axis    | out       | tvalid/tready   | ok, slot, perms, evicted, count
// cfg       | in        | cfg_we          | role registers
//
// A command scans the chain one entry per cycle by rotating it once around:
// the entry at slot 0 is probed, and the full rotation leaves the chain
// aligned. S_DECIDE settles the command, S_COMMIT writes, touches or
// compacts the cells when the table changes, and S_DONE raises tvalid.
// Synchronous reset clears the count and control; entries are not cleared.
// A new item is taken only when the previous result has been taken.
`timescale 1ns / 1ps
module keyed_access_list_table
  import kalt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
)(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[2:0], key[258:3], len[264:259], perm[272:265], time[304:273], pad
  input  logic [311:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ok[0], slot[5:1], perms[13:6], evicted[14], count[20:15], pad
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_COMMIT, S_DONE} state_t;
  state_t state;

  logic [7:0] role_mask, guest_role, admin_role;
  always_ff @(posedge clk) begin
    if (rst) begin
      role_mask <= 8'd3; guest_role <= 8'd0; admin_role <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROLE_MASK:  role_mask <= cfg_data;
        REG_GUEST_ROLE: guest_role <= cfg_data;
        REG_ADMIN_ROLE: admin_role <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key;
  logic [LEN_W-1:0]  klen;
  logic [PERM_W-1:0] perm;
  logic [TIME_W-1:0] wtime;
  logic [CW-1:0]     count;
  logic [IW:0]       step;     // rotations done
  logic [IW:0]       found;    // slot index of hit
  logic              hit;
  logic [TIME_W-1:0] hit_time;
  logic [IW:0]       victim;
  logic [TIME_W-1:0] least_time;
  logic [IW:0]       target;
  logic              ev;
  logic              res_ok;
  logic [PERM_W-1:0] res_perm;
  logic [IW:0]       res_slot;

  cell_ctl_t ctl;
  entry_t    cell_q [TABLE_DEPTH];
  entry_t    wr_entry;

  // Entry at slot 0 is the probe point; rotation index "step" tells which slot.
  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      localparam logic [IW:0] CELL_IDX = (IW+1)'(g);
      kalt_cell u_cell (
        .clk(clk), .ctl(ctl), .here(CELL_IDX == target), .above(CELL_IDX >= target),
        .wr_entry(wr_entry), .wr_time(wtime),
        .from_next(cell_q[(g + 1) % TABLE_DEPTH]), .held(cell_q[g])
      );
    end
  endgenerate

  logic [KEY_W-1:0] cmp_mask;
  logic             probe_match, probe_admin, in_range, guest_op;
  assign cmp_mask    = len_mask(cmd == CMD_PUT || (cmd == CMD_APPLY && !guest_op)
                                ? LEN_W'(32) : klen);
  assign probe_match = ((cell_q[0].key ^ key) & cmp_mask) == '0;
  assign probe_admin = (cell_q[0].perm & role_mask) == admin_role;
  assign in_range    = CW'(step) < count;
  assign guest_op    = (perm & role_mask) == guest_role;

  always_comb begin
    ctl = '0;
    // a full-key hit keeps its activity when only the permissions change
    wr_entry.key = key; wr_entry.perm = perm; wr_entry.atime = hit ? hit_time : '0;
    case (state)
      S_SCAN:  ctl.rotate = 1'b1;
      S_COMMIT: begin
        if (cmd == CMD_TOUCH) ctl.touch = 1'b1;
        else if (cmd == CMD_APPLY && guest_op) ctl.shift = 1'b1;
        else ctl.write = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          cmd   <= s_axis_tdata[2:0];
          key   <= s_axis_tdata[258:3];
          klen  <= (s_axis_tdata[264:259] > 6'd32) ? 6'd32 : s_axis_tdata[264:259];
          perm  <= s_axis_tdata[272:265];
          wtime <= s_axis_tdata[304:273];
          step <= '0; hit <= 1'b0; least_time <= TIME_MAX;
          victim <= (IW+1)'(TABLE_DEPTH - 1); ev <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (in_range && !hit) begin
            if (probe_match) begin
              hit <= 1'b1; found <= step; res_perm <= cell_q[0].perm;
              hit_time <= cell_q[0].atime;
            end else if (!probe_admin && cell_q[0].atime < least_time) begin
              victim <= step; least_time <= cell_q[0].atime;
            end
          end
          step <= step + 1'b1;
          if (CW'(step) == CW'(TABLE_DEPTH - 1)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          // chain is back at slot 0; settle the operation
          res_ok <= 1'b0; res_slot <= '0; target <= '0;
          state <= S_DONE;
          case (cmd)
            CMD_LOOKUP, CMD_TOUCH: if (hit) begin
              res_ok <= 1'b1; res_slot <= found; target <= found;
              state <= (cmd == CMD_TOUCH) ? S_COMMIT : S_DONE;
            end
            CMD_PUT: begin
              res_ok <= 1'b1;
              if (hit) res_slot <= found;
              else begin
                if (count < CW'(TABLE_DEPTH)) begin
                  target <= (IW+1)'(count); res_slot <= (IW+1)'(count);
                  count <= count + 1'b1;
                end else begin
                  target <= victim; res_slot <= victim; ev <= 1'b1;
                end
                res_perm <= perm; state <= S_COMMIT;
              end
            end
            CMD_APPLY: if (guest_op) begin
              if (hit) begin
                res_ok <= 1'b1; res_slot <= found; count <= count - 1'b1;
                target <= found; state <= S_COMMIT;
              end
            end else if (klen == 6'd32) begin
              res_ok <= 1'b1; res_perm <= perm;
              if (hit) begin
                res_slot <= found; target <= found;
              end else if (count < CW'(TABLE_DEPTH)) begin
                target <= (IW+1)'(count); res_slot <= (IW+1)'(count);
                count <= count + 1'b1;
              end else begin
                target <= victim; res_slot <= victim; ev <= 1'b1;
              end
              state <= S_COMMIT;
            end
            CMD_CLEAR: begin res_ok <= 1'b1; res_perm <= '0; count <= '0; end
            default: ;
          endcase
        end
        S_COMMIT: state <= S_DONE;
        S_DONE: begin
          if (!m_axis_tvalid) m_axis_tvalid <= 1'b1;
          else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state == S_IDLE;
  assign m_axis_tdata = {3'b0, 6'(count), res_ok & ev, res_ok ? res_perm : 8'h00,
                         res_ok ? 5'(res_slot) : 5'h00, res_ok};

  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> state == S_DONE)
    else $error("result shown outside done state");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(TABLE_DEPTH))
    else $error("count above depth");
  assert property (@(posedge clk) disable iff (rst) s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while result pending");

endmodule

// ===== tb/keyed_access_list_table_test.sv =====
// Self-checking testbench for the keyed access list table, with a scoreboard model.
`timescale 1ns / 1ps
module keyed_access_list_table_test;
  import kalt_pkg::*;

  localparam int DEPTH = 32;
  localparam int KEY_BYTE_CNT = 32;
  localparam int POOL_SIZE = 44;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [PERM_W-1:0] perm;
    logic [TIME_W-1:0] atime;
  } acl_cmd_t;

  typedef struct {
    logic       ok;
    logic [4:0] slot;
    logic [7:0] perms;
    logic       evicted;
    logic [5:0] count;
  } acl_resp_t;

  // Table model plus the queue of responses still owed by the block.
  class acl_scoreboard;
    logic [KEY_W-1:0]  keys[DEPTH];
    logic [PERM_W-1:0] perms[DEPTH];
    logic [TIME_W-1:0] times[DEPTH];
    int unsigned       entries;
    logic [7:0]        role_mask, guest_role, admin_role;
    acl_resp_t         owed[$];
    int                mismatches;

    function new();
      role_mask = 8'd3;
      guest_role = 8'd0;
      admin_role = 8'd3;
      entries = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      if (idx == REG_ROLE_MASK) role_mask = val;
      else if (idx == REG_GUEST_ROLE) guest_role = val;
      else if (idx == REG_ADMIN_ROLE) admin_role = val;
    endfunction

    function bit key_matches(int s, logic [KEY_W-1:0] key, int len);
      for (int b = 0; b < len; b++)
        if (keys[s][b*8 +: 8] != key[b*8 +: 8]) return 0;
      return 1;
    endfunction

    function int find_entry(logic [KEY_W-1:0] key, int len);
      for (int i = 0; i < entries; i++)
        if (key_matches(i, key, len)) return i;
      return -1;
    endfunction

    function int insert_key(logic [KEY_W-1:0] key, logic [7:0] init, output bit ev);
      logic [TIME_W-1:0] least;
      int victim, tgt;
      least = TIME_MAX;
      victim = DEPTH - 1;
      ev = 0;
      for (int i = 0; i < entries; i++) begin
        if (key_matches(i, key, KEY_BYTE_CNT)) return i;
        if (((perms[i] & role_mask) != admin_role) && times[i] < least) begin
          victim = i;
          least = times[i];
        end
      end
      if (entries < DEPTH) begin
        tgt = entries;
        entries++;
      end else begin
        tgt = victim;
        ev = 1;
      end
      keys[tgt] = key;
      perms[tgt] = init;
      times[tgt] = '0;
      return tgt;
    endfunction

    function void note_command(acl_cmd_t c);
      acl_resp_t r;
      int len, s;
      bit ev;
      r = '{ok: 0, slot: 0, perms: 0, evicted: 0, count: 0};
      len = (c.len > KEY_BYTE_CNT) ? KEY_BYTE_CNT : int'(c.len);
      ev = 0;
      case (c.cmd)
        CMD_LOOKUP, CMD_TOUCH: begin
          s = find_entry(c.key, len);
          if (s >= 0) begin
            if (c.cmd == CMD_TOUCH) times[s] = c.atime;
            r.ok = 1;
            r.slot = s[4:0];
            r.perms = perms[s];
          end
        end
        CMD_PUT: begin
          s = insert_key(c.key, c.perm, ev);
          r.ok = 1;
          r.slot = s[4:0];
          r.perms = perms[s];
          r.evicted = ev;
        end
        CMD_APPLY: begin
          if ((c.perm & role_mask) == guest_role) begin
            s = find_entry(c.key, len);
            if (s >= 0) begin
              r.ok = 1;
              r.slot = s[4:0];
              r.perms = perms[s];
              entries--;
              for (int i = s; i < entries; i++) begin
                keys[i] = keys[i+1];
                perms[i] = perms[i+1];
                times[i] = times[i+1];
              end
            end
          end else if (len >= KEY_BYTE_CNT) begin
            s = insert_key(c.key, 8'd0, ev);
            perms[s] = c.perm;
            r.ok = 1;
            r.slot = s[4:0];
            r.perms = c.perm;
            r.evicted = ev;
          end
        end
        CMD_CLEAR: begin
          entries = 0;
          r.ok = 1;
        end
        default: ;
      endcase
      r.count = entries[5:0];
      owed.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_response(logic [23:0] d);
      acl_resp_t e;
      if (owed.size() == 0) begin
        report($sformatf("unexpected response %h", d));
        return;
      end
      e = owed.pop_front();
      if (d[0] !== e.ok) report($sformatf("ok %b exp %b", d[0], e.ok));
      if (d[5:1] !== e.slot) report($sformatf("slot %0d exp %0d", d[5:1], e.slot));
      if (d[13:6] !== e.perms) report($sformatf("perms %h exp %h", d[13:6], e.perms));
      if (d[14] !== e.evicted) report($sformatf("evicted %b exp %b", d[14], e.evicted));
      if (d[20:15] !== e.count) report($sformatf("count %0d exp %0d", d[20:15], e.count));
    endtask
  endclass

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [311:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [23:0]  m_axis_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [7:0]   cfg_data;

  keyed_access_list_table dut (.*);

  acl_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Response side: random stalls plus one long hold-off on request.
  initial begin
    int held;
    held = 0;
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0 && held == 0) begin
        held = hold_request;
        hold_request = 0;
      end
      if (held > 0) begin
        held--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_response(m_axis_tdata);

  task send_command(acl_cmd_t c);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'b0, c.atime, c.perm, c.len, c.key, c.cmd};
    do @(posedge clk); while (!s_axis_tready);
    board.note_command(c);
    @(negedge clk);
    s_axis_tvalid <= 0;
  endtask

  task write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  task wait_quiet();
    while (board.owed.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    for (int w = 0; w < 8; w++) k[w*32 +: 32] = $urandom;
    return k;
  endfunction

  function automatic acl_cmd_t mk(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                  logic [LEN_W-1:0] len, logic [7:0] perm,
                                  logic [TIME_W-1:0] atime);
    acl_cmd_t c;
    c.cmd = cmd; c.key = key; c.len = len; c.perm = perm; c.atime = atime;
    return c;
  endfunction

  function automatic acl_cmd_t random_command();
    acl_cmd_t c;
    int pick, idx;
    pick = $urandom_range(999);
    if (pick < 350) c.cmd = CMD_PUT;
    else if (pick < 550) c.cmd = CMD_APPLY;
    else if (pick < 750) c.cmd = CMD_LOOKUP;
    else if (pick < 960) c.cmd = CMD_TOUCH;
    else if (pick < 968) c.cmd = CMD_CLEAR;
    else c.cmd = 3'($urandom_range(5, 7));
    idx = $urandom_range(POOL_SIZE - 1);
    c.key = ($urandom_range(9) == 0) ? rand_key() : key_pool[idx];
    // damage one byte so prefix lengths decide the match
    if ($urandom_range(3) == 0) begin
      idx = $urandom_range(31);
      c.key[idx*8 +: 8] = c.key[idx*8 +: 8] ^ 8'($urandom_range(1, 255));
    end
    c.len = ($urandom_range(2) == 0) ? 6'd32 : 6'($urandom_range(63));
    c.perm = 8'($urandom);
    if (c.cmd == CMD_APPLY && $urandom_range(3) == 0)
      c.perm = (board.guest_role & board.role_mask) | (8'($urandom) & ~board.role_mask);
    case ($urandom_range(5))
      0: c.atime = '0;
      1: c.atime = TIME_MAX;
      default: c.atime = $urandom;
    endcase
    return c;
  endfunction

  initial begin
    logic [KEY_W-1:0] ka, kb;
    logic [7:0] settings[4][3];
    int ph_idle, ph_stall;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_index = REG_ROLE_MASK;
    cfg_data = '0;
    ph_idle = 0;
    ph_stall = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_key();
    settings = '{'{8'h03, 8'h00, 8'h03}, '{8'hFF, 8'hFF, 8'h00},
                 '{8'h00, 8'h00, 8'h00}, '{8'h0C, 8'h04, 8'h08}};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed part
    ka = key_pool[0];
    kb = ka;
    kb[255:248] = ~kb[255:248];
    send_command(mk(CMD_LOOKUP, ka, 6'd32, 8'h00, '0));
    send_command(mk(CMD_PUT, ka, 6'd1, 8'hFF, '0));
    send_command(mk(CMD_PUT, ka, 6'd5, 8'h01, '0));
    send_command(mk(CMD_PUT, '1, 6'd32, 8'h00, '0));
    send_command(mk(CMD_PUT, '0, 6'd32, 8'h02, '0));
    send_command(mk(CMD_LOOKUP, kb, 6'd31, 8'h00, '0));
    send_command(mk(CMD_LOOKUP, kb, 6'd32, 8'h00, '0));
    send_command(mk(CMD_LOOKUP, '0, 6'd0, 8'h00, '0));
    send_command(mk(CMD_LOOKUP, '1, 6'd63, 8'h00, '0));
    send_command(mk(CMD_TOUCH, ka, 6'd40, 8'h00, TIME_MAX));
    send_command(mk(CMD_TOUCH, '1, 6'd32, 8'h00, '0));
    send_command(mk(CMD_APPLY, kb, 6'd31, 8'h01, '0));
    send_command(mk(CMD_APPLY, kb, 6'd32, 8'h03, '0));
    send_command(mk(CMD_APPLY, ka, 6'd32, 8'hFC, '0));
    send_command(mk(CMD_APPLY, '1, 6'd32, 8'h00, '0));
    send_command(mk(CMD_LOOKUP, '1, 6'd32, 8'h00, '0));
    send_command(mk(CMD_PUT, '0, 6'd32, 8'h55, '0));
    send_command(mk(3'd5, ka, 6'd32, 8'h00, '0));
    send_command(mk(3'd7, ka, 6'd32, 8'h00, '0));
    send_command(mk(CMD_CLEAR, ka, 6'd32, 8'h00, '0));
    send_command(mk(CMD_LOOKUP, ka, 6'd0, 8'h00, '0));

    // random part: one register setting and one idle pattern per phase
    for (int ph = 0; ph < 4; ph++) begin
      wait_quiet();
      write_reg(REG_ROLE_MASK, settings[ph][0]);
      write_reg(REG_GUEST_ROLE, settings[ph][1]);
      write_reg(REG_ADMIN_ROLE, settings[ph][2]);
      case (ph)
        0: begin ph_idle = 0; ph_stall = 0; end
        1: begin ph_idle = 60; ph_stall = 0; end
        2: begin ph_idle = 0; ph_stall = 60; end
        default: begin ph_idle = 6; ph_stall = 6; end
      endcase
      if (ph == 1) hold_request = 600;
      for (int n = 0; n < 420; n++) begin
        // stretches without any idling
        if (n % 140 >= 100) begin
          send_idle_pct = 0; recv_stall_pct = 0;
        end else begin
          send_idle_pct = ph_idle; recv_stall_pct = ph_stall;
        end
        send_command(random_command());
      end
    end

    while (board.owed.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
